/* rtl/dsfr_pkg.sv */
// Shared types and constants for the single-wire sensor frame receiver.
// Used by dsfr_decode and dht_sensor_frame_receiver; depends on nothing.
package dsfr_pkg;

    localparam int unsigned FRAME_BITS     = 40;
    localparam int unsigned CNT_W          = 7;
    localparam logic [CNT_W-1:0] CNT_MAX   = 7'd127;
    localparam logic [CNT_W-1:0] MIN_FRAME_BITS = 7'd30;

    localparam int unsigned TEMP_W = 12;
    localparam int unsigned HUM_W  = 11;

    localparam logic [31:0] LONG_GAP_RESET = 32'd200000000;
    localparam logic [31:0] ONE_BIT_RESET  = 32'd100000;

    // Decode limits, in whole units for the narrow format, tenths for the wide one
    localparam logic [7:0]  SMALL_TEMP_MAX = 8'd60;
    localparam logic [7:0]  SMALL_HUM_MIN  = 8'd10;
    localparam logic [7:0]  SMALL_HUM_MAX  = 8'd90;
    localparam logic [15:0] WIDE_HUM_MAX   = 16'd1100;
    localparam logic [14:0] WIDE_NEG_MAX   = 15'd500;
    localparam logic [14:0] WIDE_POS_MAX   = 15'd1350;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_BAD_DATA = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODEL_AUTO  = 2'd0,
        MODEL_SMALL = 2'd1,
        MODEL_WIDE  = 2'd2
    } model_t;

    typedef enum logic {
        CMD_EDGE    = 1'b0,
        CMD_TIMEOUT = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        REG_MODEL_SELECT = 2'd0,
        REG_LONG_GAP     = 2'd1,
        REG_ONE_BIT      = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic                     good;
        status_t                  status;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
    } decode_res_t;

endpackage

/* rtl/dsfr_decode.sv */
// Frame decoder: checksum and both data formats over the low 40 frame bits.
// Combinational; depends on dsfr_pkg.
module dsfr_decode (
    input  logic [dsfr_pkg::FRAME_BITS-1:0] frame,
    input  logic [1:0]                      model_select,
    output dsfr_pkg::decode_res_t           res
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic        small_ok, wide_ok;
    logic [dsfr_pkg::TEMP_W-1:0] small_t, wide_t;
    logic [dsfr_pkg::HUM_W-1:0]  small_h;
    logic [15:0] wide_h;
    logic [14:0] mag;
    logic        neg;
    logic        use_wide, ok;

    assign b0 = frame[7:0];
    assign b1 = frame[15:8];
    assign b2 = frame[23:16];
    assign b3 = frame[31:24];
    assign b4 = frame[39:32];

    assign sum = b1 + b2 + b3 + b4;

    // times ten as shift and add
    assign small_t  = dsfr_pkg::TEMP_W'({b2, 3'b000}) + dsfr_pkg::TEMP_W'({b2, 1'b0});
    assign small_h  = dsfr_pkg::HUM_W'({b4, 3'b000}) + dsfr_pkg::HUM_W'({b4, 1'b0});
    assign small_ok = (b1 == 8'd0) && (b3 == 8'd0) && (b2 <= dsfr_pkg::SMALL_TEMP_MAX)
                      && (b4 >= dsfr_pkg::SMALL_HUM_MIN) && (b4 <= dsfr_pkg::SMALL_HUM_MAX);

    assign wide_h  = {b4, b3};
    assign mag     = {b2[6:0], b1};
    assign neg     = b2[7];
    assign wide_t  = neg ? (~mag[dsfr_pkg::TEMP_W-1:0] + 1'b1) : mag[dsfr_pkg::TEMP_W-1:0];
    assign wide_ok = (wide_h <= dsfr_pkg::WIDE_HUM_MAX)
                     && (neg ? (mag <= dsfr_pkg::WIDE_NEG_MAX) : (mag <= dsfr_pkg::WIDE_POS_MAX));

    always_comb begin
        case (model_select)
            dsfr_pkg::MODEL_SMALL: use_wide = 1'b0;
            dsfr_pkg::MODEL_WIDE:  use_wide = 1'b1;
            default:               use_wide = wide_ok;  // auto tries the wide format first
        endcase
    end

    assign ok = use_wide ? wide_ok : small_ok;

    always_comb begin
        res.temperature = use_wide ? $signed(wide_t) : $signed(small_t);
        res.humidity    = use_wide ? wide_h[dsfr_pkg::HUM_W-1:0] : small_h;
        if (sum != b0) begin
            res.status = dsfr_pkg::ST_BAD_SUM;
            res.good   = 1'b0;
        end else if (!ok) begin
            res.status = dsfr_pkg::ST_BAD_DATA;
            res.good   = 1'b0;
        end else begin
            res.status = dsfr_pkg::ST_GOOD;
            res.good   = 1'b1;
        end
    end

endmodule

/* rtl/dht_sensor_frame_receiver.sv */
// Single-wire sensor frame receiver: edge gaps to bits, timeout to decoded reading.
// Depends on dsfr_pkg and dsfr_decode.
//
//  channel  | signals                                          | dir
//  ---------+--------------------------------------------------+-----
//  events   | s_valid s_ready s_command s_event_tick           | in
//           | s_ignore_reading                                 |
//  readings | m_valid m_ready m_status m_temperature_tenths    | out
//           | m_humidity_tenths                                |
//  config   | psel penable pwrite paddr pwdata prdata pready   | in
//
// One event per cycle while no reading is stalled: an event lands in the input
// register, and when it is processed it updates the frame state while its reading
// (if any) loads the output register.
// Reset (synchronous, aresetn low) clears the frame state, kept values and both
// valid flags, and loads the register defaults. A stalled reading holds the
// output register; the event behind it waits in the input register.
module dht_sensor_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [63:0]                       s_event_tick,
    input  logic                              s_ignore_reading,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic signed [dsfr_pkg::TEMP_W-1:0] m_temperature_tenths,
    output logic [dsfr_pkg::HUM_W-1:0]        m_humidity_tenths,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // configuration
    logic [1:0]  model_select_reg;
    logic [31:0] long_gap_reg;
    logic [31:0] one_bit_reg;
    logic        cfg_write;

    // input register
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [63:0] in_tick_reg;
    logic        in_ign_reg;

    // frame state
    logic [63:0]                     prev_tick_reg;
    logic [dsfr_pkg::FRAME_BITS-1:0] code_reg, code_next;
    logic [dsfr_pkg::CNT_W-1:0]      bit_count_reg, bit_count_next;
    logic signed [dsfr_pkg::TEMP_W-1:0] kept_temp_reg, kept_temp_next;
    logic [dsfr_pkg::HUM_W-1:0]      kept_hum_reg, kept_hum_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg;
    logic signed [dsfr_pkg::TEMP_W-1:0] m_temp_reg;
    logic [dsfr_pkg::HUM_W-1:0]      m_hum_reg;

    logic        proc_fire;
    logic        emit;
    logic [63:0] gap;
    logic        gap_long, gap_one;
    logic        frame_done;
    dsfr_pkg::decode_res_t dec;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_select_reg <= dsfr_pkg::MODEL_AUTO;
            long_gap_reg     <= dsfr_pkg::LONG_GAP_RESET;
            one_bit_reg      <= dsfr_pkg::ONE_BIT_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                dsfr_pkg::REG_MODEL_SELECT: model_select_reg <= pwdata[1:0];
                dsfr_pkg::REG_LONG_GAP:     long_gap_reg     <= pwdata;
                dsfr_pkg::REG_ONE_BIT:      one_bit_reg      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dsfr_pkg::REG_MODEL_SELECT: prdata = {30'd0, model_select_reg};
            dsfr_pkg::REG_LONG_GAP:     prdata = long_gap_reg;
            dsfr_pkg::REG_ONE_BIT:      prdata = one_bit_reg;
            default:                    prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_tick_reg <= s_event_tick;
            in_ign_reg  <= s_ignore_reading;
        end
    end

    // ---------------- frame state ----------------
    assign gap        = in_tick_reg - prev_tick_reg;
    assign gap_long   = (gap[63:32] != 32'd0) || (gap[31:0] > long_gap_reg);
    assign gap_one    = (gap[63:32] != 32'd0) || (gap[31:0] > one_bit_reg);
    assign frame_done = (in_cmd_reg == dsfr_pkg::CMD_TIMEOUT)
                        && (bit_count_reg >= dsfr_pkg::MIN_FRAME_BITS);
    assign emit       = proc_fire && frame_done && !in_ign_reg;

    dsfr_decode u_decode (
        .frame        (code_reg),
        .model_select (model_select_reg),
        .res          (dec)
    );

    always_comb begin
        code_next      = code_reg;
        bit_count_next = bit_count_reg;
        if (proc_fire) begin
            if (in_cmd_reg == dsfr_pkg::CMD_EDGE) begin
                if (gap_long) begin
                    // restart the frame
                    code_next      = '0;
                    bit_count_next = '0;
                end else begin
                    code_next = {code_reg[dsfr_pkg::FRAME_BITS-2:0], gap_one};
                    if (bit_count_reg != dsfr_pkg::CNT_MAX) begin
                        bit_count_next = bit_count_reg + 1'b1;
                    end
                end
            end else if (frame_done) begin
                code_next      = '0;
                bit_count_next = '0;
            end
        end
    end

    always_comb begin
        kept_temp_next = kept_temp_reg;
        kept_hum_next  = kept_hum_reg;
        if (emit && dec.good) begin
            kept_temp_next = dec.temperature;
            kept_hum_next  = dec.humidity;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_tick_reg <= '0;
            code_reg      <= '0;
            bit_count_reg <= '0;
            kept_temp_reg <= '0;
            kept_hum_reg  <= '0;
        end else begin
            if (proc_fire && (in_cmd_reg == dsfr_pkg::CMD_EDGE)) begin
                prev_tick_reg <= in_tick_reg;
            end
            code_reg      <= code_next;
            bit_count_reg <= bit_count_next;
            kept_temp_reg <= kept_temp_next;
            kept_hum_reg  <= kept_hum_next;
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg <= dec.status;
            m_temp_reg   <= kept_temp_next;
            m_hum_reg    <= kept_hum_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_temperature_tenths = m_temp_reg;
    assign m_humidity_tenths    = m_hum_reg;

    // ---------------- assertions ----------------
    a_result_from_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(proc_fire && (in_cmd_reg == dsfr_pkg::CMD_TIMEOUT)))
        else $error("reading produced without a timeout transaction");

    a_frame_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && frame_done) |=> (bit_count_reg == '0) && (code_reg == '0))
        else $error("frame not cleared after timeout");

    a_reading_matches_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_temp_reg == kept_temp_reg) && (m_hum_reg == kept_hum_reg))
        else $error("reading disagrees with kept values");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a blocked reading");

endmodule

/* tb/testbench.sv */
// Self-checking bench for dht_sensor_frame_receiver: streams edge and timeout
// transactions, predicts each decoded reading in-bench and checks the output.
// Depends on dsfr_pkg and the receiver RTL.
module testbench;

    localparam int ITEM_TARGET  = 1950;
    localparam int MIN_READINGS = 48;
    localparam int PHASE_ITEMS  = 200;
    localparam int MAX_PHASES   = 24;
    localparam int LONG_STALL   = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        dsfr_pkg::command_t cmd;
        logic [63:0]        tick;
        logic               ign;
    } sensor_event_t;

    typedef struct {
        dsfr_pkg::status_t                  status;
        logic signed [dsfr_pkg::TEMP_W-1:0] temperature;
        logic [dsfr_pkg::HUM_W-1:0]         humidity;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = 1'b0;
    logic [63:0] s_event_tick = '0;
    logic        s_ignore_reading = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic signed [dsfr_pkg::TEMP_W-1:0] m_temperature_tenths;
    logic [dsfr_pkg::HUM_W-1:0]         m_humidity_tenths;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Bench copy of the configuration and frame state
    logic [1:0]                         cfg_model = dsfr_pkg::MODEL_AUTO;
    logic [31:0]                        cfg_long_gap = dsfr_pkg::LONG_GAP_RESET;
    logic [31:0]                        cfg_one_bit = dsfr_pkg::ONE_BIT_RESET;
    logic [63:0]                        last_edge_tick = '0;
    logic [63:0]                        frame_code = '0;
    logic [dsfr_pkg::CNT_W-1:0]         frame_bits = '0;
    logic signed [dsfr_pkg::TEMP_W-1:0] kept_temp = '0;
    logic [dsfr_pkg::HUM_W-1:0]         kept_hum = '0;

    sensor_event_t pending_events[$];
    reading_t      expected_readings[$];
    logic [63:0]   gen_tick = '0;
    int            items_queued = 0;
    int            readings_checked = 0;
    int            mismatch_count = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            sender_gap_max = 0;
    int            ready_pct = 100;
    int            stall_requests = 0;
    int            stalls_served = 0;
    int            stall_left = 0;

    dht_sensor_frame_receiver u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_event_tick         (s_event_tick),
        .s_ignore_reading     (s_ignore_reading),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_tenths    (m_humidity_tenths),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always #5 aclk = ~aclk;

    // Checksum, then the wide and narrow layouts; updates the kept values on success
    function automatic dsfr_pkg::status_t decode_frame_bytes(input logic [39:0] f);
        logic [7:0]                         sum;
        logic [15:0]                        wide_hum;
        logic [14:0]                        wide_mag;
        logic                               wide_neg;
        logic                               wide_ok;
        logic                               small_ok;
        logic signed [dsfr_pkg::TEMP_W-1:0] wide_temp;
        sum = f[15:8] + f[23:16] + f[31:24] + f[39:32];
        if (sum != f[7:0])
            return dsfr_pkg::ST_BAD_SUM;
        wide_hum = f[39:24];
        wide_mag = f[22:8];
        wide_neg = f[23];
        wide_ok = (wide_hum <= 16'd1100) &&
                  (wide_neg ? (wide_mag <= 15'd500) : (wide_mag <= 15'd1350));
        small_ok = (f[15:8] == 8'd0) && (f[31:24] == 8'd0) && (f[23:16] <= 8'd60) &&
                   (f[39:32] >= 8'd10) && (f[39:32] <= 8'd90);
        if (cfg_model != dsfr_pkg::MODEL_SMALL && wide_ok) begin
            wide_temp = $signed({1'b0, wide_mag[10:0]});
            kept_temp = wide_neg ? -wide_temp : wide_temp;
            kept_hum = wide_hum[10:0];
            return dsfr_pkg::ST_GOOD;
        end else if (cfg_model != dsfr_pkg::MODEL_WIDE && small_ok) begin
            kept_temp = 12'(f[23:16] * 10);
            kept_hum = 11'(f[39:32] * 10);
            return dsfr_pkg::ST_GOOD;
        end
        return dsfr_pkg::ST_BAD_DATA;
    endfunction

    function automatic void apply_sensor_event(input logic cmd, input logic [63:0] tick,
                                               input logic ign);
        logic [63:0] gap;
        reading_t    r;
        if (cmd == dsfr_pkg::CMD_EDGE) begin
            gap = tick - last_edge_tick;
            last_edge_tick = tick;
            if (gap > {32'd0, cfg_long_gap}) begin
                frame_bits = '0;
                frame_code = '0;
            end else begin
                frame_code = {frame_code[62:0], gap > {32'd0, cfg_one_bit}};
                if (frame_bits != dsfr_pkg::CNT_MAX)
                    frame_bits = frame_bits + 1'b1;
            end
        end else if (frame_bits >= dsfr_pkg::MIN_FRAME_BITS) begin
            if (!ign) begin
                r.status = decode_frame_bytes(frame_code[39:0]);
                r.temperature = kept_temp;
                r.humidity = kept_hum;
                expected_readings.push_back(r);
            end
            frame_bits = '0;
            frame_code = '0;
        end
    endfunction

    function automatic void push_event(input dsfr_pkg::command_t cmd,
                                       input logic [63:0] tick, input logic ign);
        sensor_event_t item;
        item.cmd = cmd;
        item.tick = tick;
        item.ign = ign;
        pending_events.push_back(item);
        if (cmd == dsfr_pkg::CMD_EDGE)
            gen_tick = tick;
        items_queued++;
    endfunction

    task automatic write_register(input dsfr_pkg::reg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            dsfr_pkg::REG_MODEL_SELECT: cfg_model = value[1:0];
            dsfr_pkg::REG_LONG_GAP:     cfg_long_gap = value;
            dsfr_pkg::REG_ONE_BIT:      cfg_one_bit = value;
            default: ;
        endcase
    endtask

    // Drain the input queue and all pending readings, then let the pipeline settle
    task automatic wait_idle();
        @(posedge aclk);
        while (pending_events.size() != 0 || s_valid) @(posedge aclk);
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_events
        sensor_event_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                apply_sensor_event(s_command, s_event_tick, s_ignore_reading);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    next_item = pending_events.pop_front();
                    s_valid <= 1'b1;
                    s_command <= next_item.cmd;
                    s_event_tick <= next_item.tick;
                    s_ignore_reading <= next_item.ign;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // close the burst and pick the next gap
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(0, sender_gap_max);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stalls_served != stall_requests) begin
            // hold off the output while the sender keeps going
            stalls_served++;
            stall_left = LONG_STALL;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge aclk) begin : check_readings
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reading: status %0d temp %0d hum %0d",
                             m_status, m_temperature_tenths, m_humidity_tenths);
            end else begin
                want = expected_readings.pop_front();
                if (m_status !== want.status || m_temperature_tenths !== want.temperature ||
                    m_humidity_tenths !== want.humidity) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("reading %0d: expected status %0d temp %0d hum %0d, got %0d %0d %0d",
                                 readings_checked, want.status, want.temperature,
                                 want.humidity, m_status, m_temperature_tenths,
                                 m_humidity_tenths);
                end
                readings_checked++;
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          pick;
        int          nbits;
        int          phase_start;
        logic [39:0] body;
        logic [15:0] hum;
        logic [14:0] mag;
        logic        neg;
        logic [63:0] gap;
        logic [31:0] zero_max;
        logic [31:0] long_gap_val;
        logic [31:0] one_bit_val;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Threshold edges, tick wrap and timeouts on short frames, at reset settings
        push_event(dsfr_pkg::CMD_TIMEOUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_event(dsfr_pkg::CMD_TIMEOUT, 64'd0, 1'b1);
        push_event(dsfr_pkg::CMD_EDGE, 64'd0, 1'b1);
        push_event(dsfr_pkg::CMD_EDGE, gen_tick + dsfr_pkg::ONE_BIT_RESET, 1'b0);
        push_event(dsfr_pkg::CMD_EDGE, gen_tick + dsfr_pkg::ONE_BIT_RESET + 1, 1'b0);
        push_event(dsfr_pkg::CMD_EDGE, gen_tick + dsfr_pkg::LONG_GAP_RESET, 1'b1);
        push_event(dsfr_pkg::CMD_EDGE, gen_tick + dsfr_pkg::LONG_GAP_RESET + 1, 1'b0);
        push_event(dsfr_pkg::CMD_EDGE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_event(dsfr_pkg::CMD_EDGE, 64'h10, 1'b1);
        push_event(dsfr_pkg::CMD_TIMEOUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        wait_idle();

        for (phase = 0; phase < MAX_PHASES &&
             (items_queued < ITEM_TARGET || readings_checked < MIN_READINGS); phase++) begin
            write_register(dsfr_pkg::REG_MODEL_SELECT,
                           ($urandom & 32'hFFFF_FFFC) | 32'(phase % 4));
            case (phase % 6)
                0: begin
                    long_gap_val = dsfr_pkg::LONG_GAP_RESET;
                    one_bit_val = dsfr_pkg::ONE_BIT_RESET;
                end
                1: begin
                    long_gap_val = 32'd400;
                    one_bit_val = 32'd150;
                end
                2: begin
                    long_gap_val = 32'hFFFF_FFFF;
                    one_bit_val = 32'hFFFF_FFFE;
                end
                3: begin
                    long_gap_val = $urandom_range(1000, 1 << 20);
                    one_bit_val = 32'd0;
                end
                4: begin
                    // only zero gaps shift, so every frame reads as all zeros
                    long_gap_val = 32'd0;
                    one_bit_val = 32'd0;
                end
                default: begin
                    long_gap_val = $urandom;
                    one_bit_val = $urandom;
                end
            endcase
            write_register(dsfr_pkg::REG_LONG_GAP, long_gap_val);
            write_register(dsfr_pkg::REG_ONE_BIT, one_bit_val);

            if (phase == 1) begin
                sender_gap_max <= 0;
                ready_pct <= 100;
                stall_requests <= stall_requests + 1;
            end else begin
                sender_gap_max <= (phase % 4 == 0) ? 0 : (phase % 4 == 1) ? 3 :
                                  (phase % 4 == 2) ? 10 : 1;
                ready_pct <= (phase % 3 == 0) ? 100 : (phase % 3 == 1) ? 60 : 25;
            end

            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0) begin
                    // stray edges and timeouts
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(0, 1))
                            push_event(dsfr_pkg::CMD_EDGE, {$urandom, $urandom},
                                       1'($urandom));
                        else
                            push_event(dsfr_pkg::CMD_TIMEOUT, {$urandom, $urandom},
                                       1'($urandom));
                    end
                end else begin
                    pick = $urandom_range(0, 9);
                    body = '0;
                    if (pick < 3) begin
                        neg = 1'($urandom);
                        hum = 16'($urandom_range(0, 1100));
                        mag = neg ? 15'($urandom_range(0, 500)) : 15'($urandom_range(0, 1350));
                        body[39:8] = {hum, neg, mag};
                    end else if (pick < 5) begin
                        body[39:8] = {8'($urandom_range(10, 90)), 8'd0,
                                      8'($urandom_range(0, 60)), 8'd0};
                    end else if (pick == 5) begin
                        case ($urandom_range(0, 8))
                            0: body[39:8] = {16'd1100, 1'b1, 15'd500};
                            1: body[39:8] = {16'd1101, 1'b0, 15'd0};
                            2: body[39:8] = {16'd0, 1'b1, 15'd501};
                            3: body[39:8] = {16'd0, 1'b0, 15'd1350};
                            4: body[39:8] = {16'd0, 1'b0, 15'd1351};
                            5: body[39:8] = {8'd10, 8'd0, 8'd60, 8'd0};
                            6: body[39:8] = {8'd90, 8'd0, 8'd61, 8'd0};
                            7: body[39:8] = {8'd91, 8'd0, 8'd0, 8'd0};
                            default: body[39:8] = {8'd9, 8'd0, 8'd0, 8'd0};
                        endcase
                    end else begin
                        body[39:8] = $urandom;
                    end
                    body[7:0] = body[15:8] + body[23:16] + body[31:24] + body[39:32];
                    if ($urandom_range(0, 7) == 0)
                        body[7:0] = body[7:0] ^ 8'($urandom_range(1, 255));

                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                        nbits = 40;
                    else if (pick < 88)
                        nbits = $urandom_range(30, 39);
                    else if (pick < 93)
                        nbits = $urandom_range(1, 29);
                    else
                        nbits = $urandom_range(41, 135);

                    // open the frame with a restart gap
                    gap = {32'd0, cfg_long_gap} + 64'd1 +
                          ($urandom_range(0, 1) ? 64'($urandom_range(0, 1000)) :
                                                  {1'b0, 31'($urandom), $urandom});
                    push_event(dsfr_pkg::CMD_EDGE, gen_tick + gap, 1'($urandom));
                    zero_max = (cfg_one_bit < cfg_long_gap) ? cfg_one_bit : cfg_long_gap;
                    for (int i = nbits - 1; i >= 0; i--) begin
                        if (((i < 40) ? body[i] : 1'($urandom)) && cfg_one_bit < cfg_long_gap)
                            gap = ($urandom_range(0, 3) == 0) ? 64'(cfg_one_bit) + 64'd1 :
                                  64'($urandom_range(cfg_one_bit + 1, cfg_long_gap));
                        else
                            gap = ($urandom_range(0, 3) == 0) ? 64'(zero_max) :
                                  64'($urandom_range(0, zero_max));
                        push_event(dsfr_pkg::CMD_EDGE, gen_tick + gap, 1'($urandom));
                    end
                    push_event(dsfr_pkg::CMD_TIMEOUT, {$urandom, $urandom},
                               $urandom_range(0, 9) == 0);
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/dsfr_pkg.sv
rtl/dsfr_decode.sv
rtl/dht_sensor_frame_receiver.sv
tb/testbench.sv
